FILE: rtl/segment_intersection_classifier_defines.svh
// Assertion macros for the segment intersection classifier top level
`ifndef SEGMENT_INTERSECTION_CLASSIFIER_DEFINES_SVH
`define SEGMENT_INTERSECTION_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment classifier check failed");

// Next-cycle implication, disabled while reset is asserted
`define SIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment classifier check failed");

`endif

FILE: rtl/sic_pkg.sv
// Shared types and constants for the segment intersection classifier
`timescale 1ns / 1ps

package sic_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    REL_COLLINEAR   = 3'd0,
    REL_PARALLEL    = 3'd1,
    REL_LINES       = 3'd2,
    REL_SEGMENTS    = 3'd3,
    REL_A_BISECTS_B = 3'd4,
    REL_B_BISECTS_A = 3'd5
  } relation_t;

  // Per-item control that rides alongside the divider stages
  typedef struct packed {
    logic      vld;
    relation_t rel;
    logic      cv;
  } sic_side_t;

endpackage

FILE: rtl/sic_point_div.sv
// Pipelined restoring divider that places one intersection coordinate and saturates it
`timescale 1ns / 1ps

module sic_point_div import sic_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [3*COORD_WIDTH+3:0]      num_mag,
  input  logic [2*COORD_WIDTH+2:0]      den_mag,
  input  logic                          neg,
  input  logic signed [COORD_WIDTH-1:0] start,
  output logic signed [COORD_WIDTH-1:0] coord,
  output logic                          clip
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 3 * W + 4;
  localparam int DW = 2 * W + 3;
  localparam int QB = W + 1;
  localparam int SW = W + 3;

  localparam logic signed [SW-1:0] HI = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SW-1:0] LO = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  logic [DW-1:0]         rem_r   [QB+1];
  logic [DW-1:0]         den_r   [QB+1];
  logic [QB-1:0]         lo_r    [QB+1];
  logic [QB-1:0]         q_r     [QB+1];
  logic                  neg_r   [QB+1];
  logic                  ovf_r   [QB+1];
  logic signed [W-1:0]   start_r [QB+1];

  logic                  ovf_nxt;
  logic signed [SW-1:0]  qmag;
  logic signed [SW-1:0]  qsgn;
  logic signed [SW-1:0]  sum;
  logic signed [W-1:0]   coord_nxt;
  logic                  clip_nxt;
  logic signed [W-1:0]   coord_r;
  logic                  clip_r;

  // A quotient of 2^(W+1) or more lands outside the range from any start
  assign ovf_nxt = (num_mag[PW-1:QB] >= den_mag);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= num_mag[PW-1:QB];
      den_r[0]   <= den_mag;
      lo_r[0]    <= num_mag[QB-1:0];
      q_r[0]     <= '0;
      neg_r[0]   <= neg;
      ovf_r[0]   <= ovf_nxt;
      start_r[0] <= start;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    assign trial   = {rem_r[k-1], lo_r[k-1][QB-1]};
    assign diff    = trial - {1'b0, den_r[k-1]};
    assign ge      = (trial >= {1'b0, den_r[k-1]});
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= rem_nxt;
        den_r[k]   <= den_r[k-1];
        lo_r[k]    <= {lo_r[k-1][QB-2:0], 1'b0};
        q_r[k]     <= {q_r[k-1][QB-2:0], ge};
        neg_r[k]   <= neg_r[k-1];
        ovf_r[k]   <= ovf_r[k-1];
        start_r[k] <= start_r[k-1];
      end
    end
  end

  always_comb begin
    qmag = SW'(q_r[QB]);
    qsgn = neg_r[QB] ? -qmag : qmag;
    sum  = SW'(start_r[QB]) + qsgn;
    if (ovf_r[QB]) begin
      coord_nxt = neg_r[QB] ? LO[W-1:0] : HI[W-1:0];
      clip_nxt  = 1'b1;
    end else if (sum > HI) begin
      coord_nxt = HI[W-1:0];
      clip_nxt  = 1'b1;
    end else if (sum < LO) begin
      coord_nxt = LO[W-1:0];
      clip_nxt  = 1'b1;
    end else begin
      coord_nxt = sum[W-1:0];
      clip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign coord = coord_r;
  assign clip  = clip_r;

endmodule

FILE: rtl/segment_intersection_classifier.sv
// Top level of the 2D segment intersection classifier pipeline
// Takes one pair of segments per cycle while in_stall is low and returns one
// result per pair. In the pipeline, five stages form the deltas, the cross
// products and the parameter tests, then a restoring divider resolves one
// quotient bit per stage over COORD_WIDTH + 1 stages before the point is
// saturated. The output has a result register and a one-item skid; in_stall
// rises only when the skid holds an item, so input is taken every cycle while
// results are being collected. No clearing pass follows reset.
`timescale 1ns / 1ps
`include "segment_intersection_classifier_defines.svh"

module segment_intersection_classifier import sic_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_relation,
  output logic signed [COORD_WIDTH-1:0] out_cross_x,
  output logic signed [COORD_WIDTH-1:0] out_cross_y,
  output logic                          out_cross_valid,
  output logic                          out_cross_clipped
);

  localparam int W    = COORD_WIDTH;
  localparam int DLW  = W + 1;
  localparam int PRW  = 2 * W + 2;
  localparam int NW   = 2 * W + 3;
  localparam int PW   = 3 * W + 4;
  localparam int DLAT = W + 3;

  logic en;

  // Stage 1: deltas
  logic                  s1_vld_r;
  logic signed [DLW-1:0] s1_offx_r, s1_offy_r, s1_adx_r, s1_ady_r, s1_bdx_r, s1_bdy_r;
  logic signed [W-1:0]   s1_ax_r, s1_ay_r;
  logic signed [DLW-1:0] s1_offx_nxt, s1_offy_nxt, s1_adx_nxt, s1_ady_nxt;
  logic signed [DLW-1:0] s1_bdx_nxt, s1_bdy_nxt;

  // Stage 2: cross products
  logic                  s2_vld_r;
  logic signed [PRW-1:0] s2_ybx_r, s2_xby_r, s2_abd_r, s2_adb_r, s2_yax_r, s2_xay_r;
  logic signed [DLW-1:0] s2_adx_r, s2_ady_r;
  logic signed [W-1:0]   s2_ax_r, s2_ay_r;
  logic signed [PRW-1:0] s2_ybx_nxt, s2_xby_nxt, s2_abd_nxt, s2_adb_nxt;
  logic signed [PRW-1:0] s2_yax_nxt, s2_xay_nxt;

  // Stage 3: numerators and denominator
  logic                  s3_vld_r;
  logic signed [NW-1:0]  s3_tnum_r, s3_den_r, s3_unum_r;
  logic signed [DLW-1:0] s3_adx_r, s3_ady_r;
  logic signed [W-1:0]   s3_ax_r, s3_ay_r;
  logic signed [NW-1:0]  s3_tnum_nxt, s3_den_nxt, s3_unum_nxt;

  // Stage 4: classification and point products
  logic                  s4_vld_r;
  relation_t             s4_rel_r;
  logic                  s4_cv_r;
  logic signed [PW-1:0]  s4_px_r, s4_py_r;
  logic signed [NW-1:0]  s4_den_r;
  logic signed [W-1:0]   s4_ax_r, s4_ay_r;
  relation_t             s4_rel_nxt;
  logic                  s4_cv_nxt;
  logic signed [PW-1:0]  s4_px_nxt, s4_py_nxt;
  logic                  a_in, b_in;

  // Stage 5: magnitudes and quotient signs
  logic                  s5_vld_r;
  relation_t             s5_rel_r;
  logic                  s5_cv_r;
  logic [PW-1:0]         s5_pmx_r, s5_pmy_r;
  logic [NW-1:0]         s5_dm_r;
  logic                  s5_negx_r, s5_negy_r;
  logic signed [W-1:0]   s5_ax_r, s5_ay_r;
  logic [PW-1:0]         s5_pmx_nxt, s5_pmy_nxt;
  logic [NW-1:0]         s5_dm_nxt;
  logic                  s5_negx_nxt, s5_negy_nxt;

  // Divider side line and output
  sic_side_t             side_r [DLAT];
  logic signed [W-1:0]   div_x, div_y;
  logic                  clip_x, clip_y;

  logic                  out_vld_r, skid_vld_r;
  logic                  out_vld_nxt, skid_vld_nxt;
  logic                  out_load, skid_load;
  logic [2:0]            res_rel, out_rel_r, skid_rel_r;
  logic signed [W-1:0]   res_x, res_y, out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                  res_cv, res_clip, out_cv_r, out_clip_r, skid_cv_r, skid_clip_r;
  logic                  leaving, take;

  // The whole pipeline moves while the skid is empty
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // ---------------- stage 1
  always_comb begin
    s1_offx_nxt = DLW'(in_a_start_x) - DLW'(in_b_start_x);
    s1_offy_nxt = DLW'(in_a_start_y) - DLW'(in_b_start_y);
    s1_adx_nxt  = DLW'(in_a_end_x) - DLW'(in_a_start_x);
    s1_ady_nxt  = DLW'(in_a_end_y) - DLW'(in_a_start_y);
    s1_bdx_nxt  = DLW'(in_b_end_x) - DLW'(in_b_start_x);
    s1_bdy_nxt  = DLW'(in_b_end_y) - DLW'(in_b_start_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_offx_r <= s1_offx_nxt;
      s1_offy_r <= s1_offy_nxt;
      s1_adx_r  <= s1_adx_nxt;
      s1_ady_r  <= s1_ady_nxt;
      s1_bdx_r  <= s1_bdx_nxt;
      s1_bdy_r  <= s1_bdy_nxt;
      s1_ax_r   <= in_a_start_x;
      s1_ay_r   <= in_a_start_y;
    end
  end

  // ---------------- stage 2
  always_comb begin
    s2_ybx_nxt = PRW'(s1_offy_r) * PRW'(s1_bdx_r);
    s2_xby_nxt = PRW'(s1_offx_r) * PRW'(s1_bdy_r);
    s2_abd_nxt = PRW'(s1_adx_r) * PRW'(s1_bdy_r);
    s2_adb_nxt = PRW'(s1_ady_r) * PRW'(s1_bdx_r);
    s2_yax_nxt = PRW'(s1_offy_r) * PRW'(s1_adx_r);
    s2_xay_nxt = PRW'(s1_offx_r) * PRW'(s1_ady_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ybx_r <= s2_ybx_nxt;
      s2_xby_r <= s2_xby_nxt;
      s2_abd_r <= s2_abd_nxt;
      s2_adb_r <= s2_adb_nxt;
      s2_yax_r <= s2_yax_nxt;
      s2_xay_r <= s2_xay_nxt;
      s2_adx_r <= s1_adx_r;
      s2_ady_r <= s1_ady_r;
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
    end
  end

  // ---------------- stage 3
  always_comb begin
    s3_tnum_nxt = NW'(s2_ybx_r) - NW'(s2_xby_r);
    s3_den_nxt  = NW'(s2_abd_r) - NW'(s2_adb_r);
    s3_unum_nxt = NW'(s2_yax_r) - NW'(s2_xay_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tnum_r <= s3_tnum_nxt;
      s3_den_r  <= s3_den_nxt;
      s3_unum_r <= s3_unum_nxt;
      s3_adx_r  <= s2_adx_r;
      s3_ady_r  <= s2_ady_r;
      s3_ax_r   <= s2_ax_r;
      s3_ay_r   <= s2_ay_r;
    end
  end

  // ---------------- stage 4
  // A parameter lies in [0,1] when its numerator shares the sign of the
  // denominator and does not exceed it in magnitude; both ends count as inside
  always_comb begin
    if (!s3_den_r[NW-1]) begin
      a_in = !s3_tnum_r[NW-1] && (s3_tnum_r <= s3_den_r);
      b_in = !s3_unum_r[NW-1] && (s3_unum_r <= s3_den_r);
    end else begin
      a_in = (s3_tnum_r[NW-1] || (s3_tnum_r == '0)) && (s3_tnum_r >= s3_den_r);
      b_in = (s3_unum_r[NW-1] || (s3_unum_r == '0)) && (s3_unum_r >= s3_den_r);
    end

    s4_cv_nxt = (s3_den_r != '0);
    if (!s4_cv_nxt) begin
      s4_rel_nxt = (s3_tnum_r == '0) ? REL_COLLINEAR : REL_PARALLEL;
    end else if (a_in && b_in) begin
      s4_rel_nxt = REL_SEGMENTS;
    end else if (b_in) begin
      s4_rel_nxt = REL_A_BISECTS_B;
    end else if (a_in) begin
      s4_rel_nxt = REL_B_BISECTS_A;
    end else begin
      s4_rel_nxt = REL_LINES;
    end

    s4_px_nxt = PW'(s3_tnum_r) * PW'(s3_adx_r);
    s4_py_nxt = PW'(s3_tnum_r) * PW'(s3_ady_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rel_r <= s4_rel_nxt;
      s4_cv_r  <= s4_cv_nxt;
      s4_px_r  <= s4_px_nxt;
      s4_py_r  <= s4_py_nxt;
      s4_den_r <= s3_den_r;
      s4_ax_r  <= s3_ax_r;
      s4_ay_r  <= s3_ay_r;
    end
  end

  // ---------------- stage 5
  always_comb begin
    s5_pmx_nxt  = s4_px_r[PW-1] ? PW'(-s4_px_r) : PW'(s4_px_r);
    s5_pmy_nxt  = s4_py_r[PW-1] ? PW'(-s4_py_r) : PW'(s4_py_r);
    s5_dm_nxt   = s4_den_r[NW-1] ? NW'(-s4_den_r) : NW'(s4_den_r);
    s5_negx_nxt = s4_px_r[PW-1] ^ s4_den_r[NW-1];
    s5_negy_nxt = s4_py_r[PW-1] ^ s4_den_r[NW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rel_r  <= s4_rel_r;
      s5_cv_r   <= s4_cv_r;
      s5_pmx_r  <= s5_pmx_nxt;
      s5_pmy_r  <= s5_pmy_nxt;
      s5_dm_r   <= s5_dm_nxt;
      s5_negx_r <= s5_negx_nxt;
      s5_negy_r <= s5_negy_nxt;
      s5_ax_r   <= s4_ax_r;
      s5_ay_r   <= s4_ay_r;
    end
  end

  // ---------------- dividers and side line
  sic_point_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
    .clk     (clk),
    .en      (en),
    .num_mag (s5_pmx_r),
    .den_mag (s5_dm_r),
    .neg     (s5_negx_r),
    .start   (s5_ax_r),
    .coord   (div_x),
    .clip    (clip_x)
  );

  sic_point_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
    .clk     (clk),
    .en      (en),
    .num_mag (s5_pmy_r),
    .den_mag (s5_dm_r),
    .neg     (s5_negy_r),
    .start   (s5_ay_r),
    .coord   (div_y),
    .clip    (clip_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLAT; i++) begin
        side_r[i] <= '0;
      end
    end else if (en) begin
      side_r[0] <= '{vld: s5_vld_r, rel: s5_rel_r, cv: s5_cv_r};
      for (int i = 1; i < DLAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Parallel and collinear pairs carry no point
  always_comb begin
    res_rel  = side_r[DLAT-1].rel;
    res_cv   = side_r[DLAT-1].cv;
    res_x    = res_cv ? div_x : '0;
    res_y    = res_cv ? div_y : '0;
    res_clip = res_cv && (clip_x || clip_y);
  end

  // ---------------- output register and skid
  assign leaving = en && side_r[DLAT-1].vld;
  assign take    = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    if (skid_vld_r) begin
      if (take) begin
        out_load     = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (!out_vld_r || take) begin
      out_load    = 1'b1;
      out_vld_nxt = leaving;
    end else if (leaving) begin
      skid_load    = 1'b1;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_vld_r) begin
        out_rel_r  <= skid_rel_r;
        out_x_r    <= skid_x_r;
        out_y_r    <= skid_y_r;
        out_cv_r   <= skid_cv_r;
        out_clip_r <= skid_clip_r;
      end else begin
        out_rel_r  <= res_rel;
        out_x_r    <= res_x;
        out_y_r    <= res_y;
        out_cv_r   <= res_cv;
        out_clip_r <= res_clip;
      end
    end
    if (skid_load) begin
      skid_rel_r  <= res_rel;
      skid_x_r    <= res_x;
      skid_y_r    <= res_y;
      skid_cv_r   <= res_cv;
      skid_clip_r <= res_clip;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_relation      = out_rel_r;
  assign out_cross_x       = out_x_r;
  assign out_cross_y       = out_y_r;
  assign out_cross_valid   = out_cv_r;
  assign out_cross_clipped = out_clip_r;

  // ---------------- checks
  `SIC_ASSERT_NOW(a_skid_needs_out, clk, rst_n, skid_vld_r, out_vld_r)
  `SIC_ASSERT_NOW(a_skid_fill_on_stall, clk, rst_n, $rose(skid_vld_r), $past(out_vld_r && out_stall))
  `SIC_ASSERT_NOW(a_no_point_zero, clk, rst_n, out_vld_r && !out_cv_r, (out_x_r == '0) && (out_y_r == '0) && !out_clip_r)
  `SIC_ASSERT_NOW(a_cv_matches_rel, clk, rst_n, out_vld_r, out_cv_r == ((out_rel_r != REL_COLLINEAR) && (out_rel_r != REL_PARALLEL)))

endmodule
